>>> hdl/kar_pkg.sv
// Package for the key auto-repeat block: shared types, register indexes,
// repeat phases and reset values. No dependencies.
package kar_pkg;

    localparam int DataW  = 32;
    localparam int DelayW = 16;
    localparam int IndexW = 2;

    localparam logic [DelayW-1:0] InitialDelayReset = 16'd300;
    localparam logic [DelayW-1:0] RepeatDelayReset  = 16'd150;
    localparam logic [DataW-1:0]  UpMaskReset       = 32'h0000_0800;
    localparam logic [DataW-1:0]  DownMaskReset     = 32'h0000_0400;

    typedef enum logic [IndexW-1:0] {
        REG_INITIAL_DELAY = 2'd0,
        REG_REPEAT_DELAY  = 2'd1,
        REG_UP_MASK       = 2'd2,
        REG_DOWN_MASK     = 2'd3
    } cfg_index_t;

    typedef enum logic [1:0] {
        PHASE_OFF   = 2'd0,
        PHASE_FIRST = 2'd1,
        PHASE_NEXT  = 2'd2
    } phase_t;

    typedef struct packed {
        logic [DelayW-1:0] initial_delay;
        logic [DelayW-1:0] repeat_delay;
        logic [DataW-1:0]  up_mask;
        logic [DataW-1:0]  down_mask;
    } cfg_t;

    typedef struct packed {
        logic [DataW-1:0] pressed;
        logic [DataW-1:0] held;
        logic [DataW-1:0] now;
    } poll_t;

    typedef struct packed {
        logic [DataW-1:0] keys;
        logic             rep;
    } result_t;

endpackage

>>> hdl/kar_cfg_regs.sv
// Configuration registers of the key auto-repeat block.
// Depends on kar_pkg for the register indexes, reset values and cfg_t.
module kar_cfg_regs
    import kar_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  logic [IndexW-1:0] wr_index,
    input  logic [DataW-1:0]  wr_data,
    output cfg_t              cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (cfg_index_t'(wr_index))
                REG_INITIAL_DELAY: cfg_next.initial_delay = wr_data[DelayW-1:0];
                REG_REPEAT_DELAY:  cfg_next.repeat_delay  = wr_data[DelayW-1:0];
                REG_UP_MASK:       cfg_next.up_mask       = wr_data;
                REG_DOWN_MASK:     cfg_next.down_mask     = wr_data;
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.initial_delay <= InitialDelayReset;
            cfg_reg.repeat_delay  <= RepeatDelayReset;
            cfg_reg.up_mask       <= UpMaskReset;
            cfg_reg.down_mask     <= DownMaskReset;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> hdl/kar_repeat_core.sv
// Repeat decision for one poll: phase and timestamp state, elapsed-time
// compare and result selection. Depends on kar_pkg.
module kar_repeat_core
    import kar_pkg::*;
#(
    parameter int KEY_BITS = 32
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    fire,
    input  poll_t   poll,
    input  cfg_t    cfg,
    output result_t result
);

    localparam logic [DataW-1:0] KeyMask =
        (KEY_BITS >= DataW) ? {DataW{1'b1}} : DataW'((64'd1 << KEY_BITS) - 64'd1);

    phase_t           phase_reg;
    phase_t           phase_next;
    logic [DataW-1:0] last_reg;
    logic [DataW-1:0] last_next;

    logic [DataW-1:0]  pressed;
    logic [DataW-1:0]  held;
    logic [DataW-1:0]  up_mask;
    logic [DataW-1:0]  down_mask;
    logic [DataW-1:0]  elapsed;
    logic [DelayW-1:0] wait_ms;
    logic              any_press;
    logic              arm_press;
    logic              still_held;
    logic              due;

    assign pressed    = poll.pressed & KeyMask;
    assign held       = poll.held & KeyMask;
    assign up_mask    = cfg.up_mask & KeyMask;
    assign down_mask  = cfg.down_mask & KeyMask;
    assign any_press  = |pressed;
    assign arm_press  = |(pressed & (up_mask | down_mask));
    assign still_held = |(held & (up_mask | down_mask));
    assign elapsed    = poll.now - last_reg;

    always_comb
    begin
        unique case (phase_reg)
            PHASE_FIRST: wait_ms = cfg.initial_delay;
            default:     wait_ms = cfg.repeat_delay;
        endcase
    end

    assign due = (phase_reg != PHASE_OFF) && still_held
                 && (elapsed > {{(DataW-DelayW){1'b0}}, wait_ms});

    always_comb
    begin
        phase_next = phase_reg;
        last_next  = last_reg;
        priority if (any_press)
        begin
            if (arm_press)
            begin
                phase_next = PHASE_FIRST;
                last_next  = poll.now;
            end
            else
            begin
                phase_next = PHASE_OFF;
            end
        end
        else if (phase_reg != PHASE_OFF)
        begin
            if (!still_held)
            begin
                phase_next = PHASE_OFF;
            end
            else if (due)
            begin
                phase_next = PHASE_NEXT;
                last_next  = poll.now;
            end
        end
    end

    always_comb
    begin
        result.keys = '0;
        result.rep  = 1'b0;
        priority if (any_press)
        begin
            result.keys = pressed;
        end
        else if (due)
        begin
            result.keys = (|(held & up_mask)) ? up_mask : down_mask;
            result.rep  = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PHASE_OFF;
            last_reg  <= '0;
        end
        else if (fire)
        begin
            phase_reg <= phase_next;
            last_reg  <= last_next;
        end
    end

endmodule

>>> hdl/key_autorepeat_up_down.sv
// Flow: a transferred poll waits in the input register; its result is loaded
// into the result register once the output side is free, and is then on the
// output.
// Throughput: one poll per cycle while results are taken; a stalled result lets
// one more poll into the input register, then the input stalls until it drains.
// Reset: empties both registers, sets the delays and key masks to their
// defaults, disarms repeat and clears the recorded time.
module key_autorepeat_up_down
    import kar_pkg::*;
#(
    parameter int KEY_BITS = 32
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [DataW-1:0]  pressed_keys,
    input  logic [DataW-1:0]  held_keys,
    input  logic [DataW-1:0]  now_ms,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [DataW-1:0]  keys_out,
    output logic              is_repeat,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [IndexW-1:0] cfg_index,
    input  logic [DataW-1:0]  cfg_data
);

    logic    s1_valid_reg;
    poll_t   s1_poll_reg;
    logic    out_valid_reg;
    result_t out_reg;
    result_t core_result;
    cfg_t    cfg;
    logic    advance;

    assign cfg_ready = 1'b1;

    kar_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid & cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    assign advance  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || advance;

    kar_repeat_core #(
        .KEY_BITS (KEY_BITS)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (advance),
        .poll   (s1_poll_reg),
        .cfg    (cfg),
        .result (core_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (!out_valid_reg || out_ready)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_poll_reg.pressed <= pressed_keys;
            s1_poll_reg.held    <= held_keys;
            s1_poll_reg.now     <= now_ms;
        end
        if (advance)
        begin
            out_reg <= core_result;
        end
    end

    assign out_valid = out_valid_reg;
    assign keys_out  = out_reg.keys;
    assign is_repeat = out_reg.rep;

endmodule

>>> hdl/kar_checker.sv
// Port-level checks for key_autorepeat_up_down, attached by bind.
// Depends on kar_pkg for the field widths.
module kar_checker
    import kar_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             in_ready,
    input logic             out_valid,
    input logic             out_ready,
    input logic [DataW-1:0] keys_out,
    input logic             is_repeat
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped before transfer");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(keys_out) && $stable(is_repeat))
        else $error("stalled result changed");

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled while output side is free");

    a_repeat_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_repeat |-> keys_out != '0)
        else $error("repeat result with empty key mask");

endmodule

bind key_autorepeat_up_down kar_checker u_kar_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .keys_out  (keys_out),
    .is_repeat (is_repeat)
);
